// ----- hw/rtl/lcd_window_framebuffer_controller_macros.svh -----
// ----------------------------------------------------------------------------
// LCD window frame buffer controller: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_FRAMEBUFFER_CONTROLLER_MACROS_SVH
`define LCD_WINDOW_FRAMEBUFFER_CONTROLLER_MACROS_SVH

// prop must hold at every clock edge out of reset
`define LWFC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lwfc: assertion failed");

// cond must never be true at a clock edge out of reset
`define LWFC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lwfc: forbidden condition seen");

`endif

// ----- hw/rtl/lwfc_pkg.sv -----
// ----------------------------------------------------------------------------
// lwfc_pkg
// Codes and controller/datapath interface types for the LCD window
// frame buffer controller.
// ----------------------------------------------------------------------------
package lwfc_pkg;

  // bus item kinds (in_tuser)
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // LCD command codes
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input request taken this cycle
    logic clr_we;     // write zero at clear counter
    logic mod_start;  // load address reduction unit, advance write pointer on a write
    logic mem_we;     // write data byte at reduced address
    logic rd_a0;      // read high byte of pixel
    logic rd_a1;      // read low byte of pixel
    logic pix_load;   // capture pixel word
    logic out_load;   // load output register
  } lwfc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic out_free;
    logic is_read;      // operation in flight is a pixel read
    logic in_mem_write; // offered item is a frame store data byte
    logic in_read;      // offered item is a pixel read
    logic in_visible;   // offered read coordinates inside visible area
  } lwfc_sts_t;

endpackage

// ----- hw/rtl/lwfc_mod.sv -----
// ----------------------------------------------------------------------------
// lwfc_mod
// Reduction of a linear address modulo the store size by reciprocal
// multiplication: quotient estimate, remainder, one correction step.
// ----------------------------------------------------------------------------
module lwfc_mod #(
  parameter int V_W         = 28,
  parameter int STORE_BYTES = 131072
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [V_W-1:0]                 v_in,
  output logic [$clog2(STORE_BYTES)-1:0] rem,
  output logic                           done
);

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int Q_W    = V_W - ADDR_W + 1;
  localparam int P_W    = V_W + Q_W;
  // floor(2^V_W / STORE_BYTES): the quotient estimate is low by at most one
  localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << V_W) / 64'(STORE_BYTES));

  logic [V_W-1:0]    v_r, v_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [ADDR_W:0]   r_est_r, r_est_nxt;
  logic [ADDR_W-1:0] r_r, r_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [P_W-1:0]    prod;
  logic [V_W-1:0]    qs;
  logic [V_W-1:0]    diff;

  assign prod = P_W'(v_r) * P_W'(RECIP);
  assign qs   = V_W'(q_r) * V_W'(STORE_BYTES);
  assign diff = v_r - qs;

  always_comb begin
    v_nxt     = v_r;
    q_nxt     = q_r;
    r_est_nxt = r_est_r;
    r_nxt     = r_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      v_nxt   = v_in;
      cnt_nxt = 2'd3;
    end else begin
      unique case (cnt_r)
        2'd3: begin
          q_nxt   = prod[P_W-1:V_W];
          cnt_nxt = 2'd2;
        end
        2'd2: begin
          // below twice the store size
          r_est_nxt = diff[ADDR_W:0];
          cnt_nxt   = 2'd1;
        end
        2'd1: begin
          if (r_est_r >= (ADDR_W+1)'(STORE_BYTES)) begin
            r_nxt = ADDR_W'(r_est_r - (ADDR_W+1)'(STORE_BYTES));
          end else begin
            r_nxt = r_est_r[ADDR_W-1:0];
          end
          cnt_nxt = 2'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    v_r     <= v_nxt;
    q_r     <= q_nxt;
    r_est_r <= r_est_nxt;
    r_r     <= r_nxt;
  end

  assign rem  = r_r;
  assign done = (cnt_r == '0);

endmodule

// ----- hw/rtl/lwfc_dp.sv -----
// ----------------------------------------------------------------------------
// lwfc_dp
// Datapath: command decode registers, window and write pointer, frame
// store, address reduction and output register.
// ----------------------------------------------------------------------------
module lwfc_dp #(
  parameter int STORE_BYTES     = 131072,
  parameter int ROW_PITCH_BYTES = 1024,
  parameter int VISIBLE_COLUMNS = 160,
  parameter int VISIBLE_ROWS    = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lwfc_pkg::lwfc_cmd_t cmd,
  output lwfc_pkg::lwfc_sts_t sts,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_byte,
  input  logic [7:0]         in_col,
  input  logic [6:0]         in_row,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata
);

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int PITCH_W = $clog2(ROW_PITCH_BYTES + 1);
  localparam int V_W     = 16 + PITCH_W + 1;

  // command and window state
  logic [7:0]  cur_cmd_r, cur_cmd_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] col_start_r, col_start_nxt;
  logic [15:0] col_end_r, col_end_nxt;
  logic [15:0] row_start_r, row_start_nxt;
  logic [15:0] row_end_r, row_end_nxt;
  logic [17:0] ptr_x_r, ptr_x_nxt;
  logic [15:0] ptr_row_r, ptr_row_nxt;

  // operands of the item in flight
  logic [7:0]  data_r;
  logic [7:0]  rd_col_r;
  logic [6:0]  rd_row_r;
  logic        sel_read_r;

  // store, read path, output
  logic [7:0]        store_r [STORE_BYTES];
  logic [7:0]        q_r;
  logic [7:0]        hi_r;
  logic [15:0]       pix_r;
  logic [23:0]       out_data_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [7:0]        win_b;
  logic [15:0]       win_first, win_last;
  logic [17:0]       x_inc, x_lim;
  logic [15:0]       row_inc;
  logic [15:0]       mul_row;
  logic [17:0]       mul_x;
  logic [V_W-1:0]    lin_addr;
  logic [ADDR_W-1:0] addr0;
  logic [ADDR_W:0]   addr1_t;
  logic [ADDR_W-1:0] addr1;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mod_done;

  // window register pair addressed by the current command
  always_comb begin
    win_b     = in_byte;
    win_first = (cur_cmd_r == lwfc_pkg::CMD_ROW_SET) ? row_start_r : col_start_r;
    win_last  = (cur_cmd_r == lwfc_pkg::CMD_ROW_SET) ? row_end_r : col_end_r;
    unique case (step_r)
      3'd0:    win_first = {win_b, win_first[7:0]};
      3'd1:    win_first = {win_first[15:8], win_b};
      3'd2:    win_last  = {win_b, win_last[7:0]};
      3'd3:    win_last  = {win_last[15:8], win_b};
      default: ;
    endcase
  end

  assign x_inc   = ptr_x_r + 18'd1;
  assign x_lim   = {1'b0, col_end_r, 1'b1};
  assign row_inc = ptr_row_r + 16'd1;

  always_comb begin
    cur_cmd_nxt   = cur_cmd_r;
    step_nxt      = step_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_start_nxt = row_start_r;
    row_end_nxt   = row_end_r;
    ptr_x_nxt     = ptr_x_r;
    ptr_row_nxt   = ptr_row_r;
    if (cmd.accept) begin
      if (in_kind == lwfc_pkg::KIND_CMD) begin
        cur_cmd_nxt = in_byte;
        step_nxt    = 3'd0;
        if (in_byte == lwfc_pkg::CMD_MEMORY_WRITE) begin
          ptr_x_nxt   = {1'b0, col_start_r, 1'b0};
          ptr_row_nxt = row_start_r;
        end
      end else if (in_kind == lwfc_pkg::KIND_DATA) begin
        if (cur_cmd_r == lwfc_pkg::CMD_ROW_SET) begin
          row_start_nxt = win_first;
          row_end_nxt   = win_last;
          if (step_r < 3'd4) step_nxt = step_r + 3'd1;
        end else if (cur_cmd_r == lwfc_pkg::CMD_COLUMN_SET) begin
          col_start_nxt = win_first;
          col_end_nxt   = win_last;
          if (step_r < 3'd4) step_nxt = step_r + 3'd1;
        end
      end
    end
    // write pointer moves once the old position is captured for addressing
    if (cmd.mod_start && !sel_read_r) begin
      ptr_x_nxt = x_inc;
      if (x_inc > x_lim) begin
        ptr_x_nxt   = {1'b0, col_start_r, 1'b0};
        ptr_row_nxt = (row_inc > row_end_r) ? row_start_r : row_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cmd_r   <= '0;
      step_r      <= '0;
      col_start_r <= '0;
      col_end_r   <= '0;
      row_start_r <= '0;
      row_end_r   <= '0;
      ptr_x_r     <= '0;
      ptr_row_r   <= '0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      cur_cmd_r   <= cur_cmd_nxt;
      step_r      <= step_nxt;
      col_start_r <= col_start_nxt;
      col_end_r   <= col_end_nxt;
      row_start_r <= row_start_nxt;
      row_end_r   <= row_end_nxt;
      ptr_x_r     <= ptr_x_nxt;
      ptr_row_r   <= ptr_row_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clr_we) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // item operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_r     <= in_byte;
      rd_col_r   <= in_col;
      rd_row_r   <= in_row;
      sel_read_r <= (in_kind == lwfc_pkg::KIND_READ);
    end
  end

  // linear address: row * pitch + byte column
  assign mul_row  = sel_read_r ? {9'd0, rd_row_r} : ptr_row_r;
  assign mul_x    = sel_read_r ? {9'd0, rd_col_r, 1'b0} : ptr_x_r;
  assign lin_addr = V_W'(mul_row) * V_W'(ROW_PITCH_BYTES) + V_W'(mul_x);

  lwfc_mod #(
    .V_W         (V_W),
    .STORE_BYTES (STORE_BYTES)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .v_in  (lin_addr),
    .rem   (addr0),
    .done  (mod_done)
  );

  assign addr1_t = {1'b0, addr0} + (ADDR_W+1)'(1);
  assign addr1   = (addr1_t == (ADDR_W+1)'(STORE_BYTES)) ? '0 : addr1_t[ADDR_W-1:0];
  assign rd_addr = cmd.rd_a1 ? addr1 : addr0;
  assign wr_addr = cmd.clr_we ? clr_cnt_r : addr0;

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_we || cmd.mem_we) begin
      store_r[wr_addr] <= cmd.clr_we ? 8'd0 : data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a0 || cmd.rd_a1) q_r <= store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a1) hi_r <= q_r;
    if (cmd.accept) begin
      pix_r <= '0;
    end else if (cmd.pix_load) begin
      pix_r <= {hi_r, q_r};
    end
    if (cmd.out_load) begin
      out_data_r <= {pix_r[4:0], 3'b000, pix_r[10:5], 2'b00, pix_r[15:11], 3'b000};
    end
  end

  assign sts.clr_last     = (clr_cnt_r == ADDR_W'(STORE_BYTES - 1));
  assign sts.mod_done     = mod_done;
  assign sts.out_free     = !out_valid_r || out_tready;
  assign sts.is_read      = sel_read_r;
  assign sts.in_mem_write = (in_kind == lwfc_pkg::KIND_DATA) &&
                            (cur_cmd_r == lwfc_pkg::CMD_MEMORY_WRITE);
  assign sts.in_read      = (in_kind == lwfc_pkg::KIND_READ);
  assign sts.in_visible   = (int'(in_col) < VISIBLE_COLUMNS) &&
                            (int'(in_row) < VISIBLE_ROWS);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/lwfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lwfc_ctrl
// Controller state machine: store clear after reset, request intake and
// sequencing of address reduction, store access and result delivery.
// ----------------------------------------------------------------------------
module lwfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lwfc_pkg::lwfc_sts_t sts,
  output lwfc_pkg::lwfc_cmd_t cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_MOD   = 4'd3;
  localparam logic [3:0] ST_WR    = 4'd4;
  localparam logic [3:0] ST_RA    = 4'd5;
  localparam logic [3:0] ST_RB    = 4'd6;
  localparam logic [3:0] ST_RC    = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          priority if (sts.in_mem_write) begin
            state_nxt = ST_MUL;
          end else if (sts.in_read) begin
            state_nxt = sts.in_visible ? ST_MUL : ST_OUT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        cmd.mod_start = 1'b1;
        state_nxt     = ST_MOD;
      end
      ST_MOD: begin
        if (sts.mod_done) state_nxt = sts.is_read ? ST_RA : ST_WR;
      end
      ST_WR: begin
        cmd.mem_we = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RA: begin
        cmd.rd_a0 = 1'b1;
        state_nxt = ST_RB;
      end
      ST_RB: begin
        cmd.rd_a1 = 1'b1;
        state_nxt = ST_RC;
      end
      ST_RC: begin
        cmd.pix_load = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/lcd_window_framebuffer_controller.sv -----
// ----------------------------------------------------------------------------
// lcd_window_framebuffer_controller
// LCD bus front end with windowed byte writes into a frame store and
// RGB565 pixel readback expanded to 8-bit channels.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tuser: item kind; tdata: byte, col, row
//   out_     out  out_tvalid/out_tready  tdata: red, green, blue
//
// Command bytes, window bytes and ignored items are taken in idle; an invisible
// pixel read passes through the output state only. A frame store data byte and
// a visible pixel read pass through address multiply, reciprocal reduction
// modulo STORE_BYTES, then the store access. No new item is taken until the
// last one is through. After reset the store is cleared one byte a cycle, with
// in_tready low. A read result waits in the output register; a following
// read stalls in its output state until that register is taken.
// ----------------------------------------------------------------------------
module lcd_window_framebuffer_controller #(
  parameter int STORE_BYTES     = 131072,
  parameter int ROW_PITCH_BYTES = 1024,
  parameter int VISIBLE_COLUMNS = 160,
  parameter int VISIBLE_ROWS    = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] byte_value, [15:8] read_column,
                                  // [22:16] read_row, [23] zero
  input  logic [1:0]  in_tuser,   // [1:0] item kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  lwfc_pkg::lwfc_cmd_t cmd;
  lwfc_pkg::lwfc_sts_t sts;

  lwfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lwfc_dp #(
    .STORE_BYTES     (STORE_BYTES),
    .ROW_PITCH_BYTES (ROW_PITCH_BYTES),
    .VISIBLE_COLUMNS (VISIBLE_COLUMNS),
    .VISIBLE_ROWS    (VISIBLE_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_byte    (in_tdata[7:0]),
    .in_col     (in_tdata[15:8]),
    .in_row     (in_tdata[22:16]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hw/rtl/lwfc_checker.sv -----
// ----------------------------------------------------------------------------
// lwfc_checker
// Port-level checks for the LCD window frame buffer controller.
// ----------------------------------------------------------------------------
`include "lcd_window_framebuffer_controller_macros.svh"

module lwfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result stays put
  `LWFC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // a read request keeps the block busy until its result is loaded
  `LWFC_ASSERT(a_read_busy, clk, rst_n, in_tvalid && in_tready && in_tuser == lwfc_pkg::KIND_READ |=> !in_tready)

  // write and command requests never produce a result
  `LWFC_ASSERT(a_no_spurious, clk, rst_n, in_tvalid && in_tready && in_tuser != lwfc_pkg::KIND_READ && !out_tvalid |=> !out_tvalid)

  // store clear holds off requests right after reset
  `LWFC_ASSERT_NEVER(a_clear_first, clk, rst_n, $past(!rst_n) && in_tready)

endmodule

bind lcd_window_framebuffer_controller lwfc_checker u_lwfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- dv/lcd_window_framebuffer_controller_test.sv -----
// ----------------------------------------------------------------------------
// lcd_window_framebuffer_controller_test
// Self-checking bench for the LCD window frame buffer controller. Sends
// command bytes, window and frame store data bytes, and pixel reads. It
// keeps its own copy of the window registers, write pointer and frame
// store to predict random RGB readbacks, and checks each field by field.
// Sender idles and receiver stalls are varied in phases.
// ----------------------------------------------------------------------------
module lcd_window_framebuffer_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES     = 131072;
  localparam int ROW_PITCH_BYTES = 1024;
  localparam int VISIBLE_COLUMNS = 160;
  localparam int VISIBLE_ROWS    = 128;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         TARGET_ITEMS = 500;
  // long enough to cover the clear pass after reset, in which no request is taken
  localparam int         STALL_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] col;
    logic [6:0] row;
    bit         typed;
    pixel_t     px;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = lwfc_pkg::KIND_CMD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  lcd_window_framebuffer_controller #(
    .STORE_BYTES    (STORE_BYTES),
    .ROW_PITCH_BYTES(ROW_PITCH_BYTES),
    .VISIBLE_COLUMNS(VISIBLE_COLUMNS),
    .VISIBLE_ROWS   (VISIBLE_ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the controller state
  bit   [7:0]  frame_mem [STORE_BYTES];
  logic [7:0]  cur_cmd = '0;
  int unsigned win_step = 0;
  logic [15:0] col_first = '0, col_last = '0, row_first = '0, row_last = '0;
  logic [17:0] ptr_x = '0;
  logic [15:0] ptr_row = '0;

  pixel_t pixel_q [$];
  int     errors = 0;
  int     sent_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     quiet_cycles = 0;

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  // pair = {first, last}; bytes arrive first high, first low, last high, last low
  function automatic logic [31:0] window_load(input logic [31:0] pair, input logic [7:0] b);
    logic [31:0] upd;
    upd = pair;
    case (win_step)
      0: upd[31:24] = b;
      1: upd[23:16] = b;
      2: upd[15:8]  = b;
      3: upd[7:0]   = b;
      default: ;
    endcase
    return upd;
  endfunction

  function automatic bit lcd_apply(input logic [1:0] kind, input logic [7:0] value,
                                   input logic [7:0] col, input logic [6:0] row,
                                   output pixel_t px);
    longint unsigned addr;
    logic [15:0]     word;
    bit              has_px;
    px = '0;
    has_px = 1'b0;
    case (kind)
      lwfc_pkg::KIND_CMD: begin
        cur_cmd = value;
        win_step = 0;
        if (value == lwfc_pkg::CMD_MEMORY_WRITE) begin
          ptr_x = {1'b0, col_first, 1'b0};
          ptr_row = row_first;
        end
      end
      lwfc_pkg::KIND_DATA: begin
        if (cur_cmd == lwfc_pkg::CMD_ROW_SET) begin
          {row_first, row_last} = window_load({row_first, row_last}, value);
          if (win_step < 4) win_step++;
        end else if (cur_cmd == lwfc_pkg::CMD_COLUMN_SET) begin
          {col_first, col_last} = window_load({col_first, col_last}, value);
          if (win_step < 4) win_step++;
        end else if (cur_cmd == lwfc_pkg::CMD_MEMORY_WRITE) begin
          addr = (longint'(ptr_x) + longint'(ptr_row) * ROW_PITCH_BYTES) % STORE_BYTES;
          frame_mem[addr] = value;
          ptr_x = ptr_x + 18'd1;
          if (ptr_x > {1'b0, col_last, 1'b1}) begin
            ptr_x = {1'b0, col_first, 1'b0};
            ptr_row = ptr_row + 16'd1;
            if (ptr_row > row_last) ptr_row = row_first;
          end
        end
      end
      lwfc_pkg::KIND_READ: begin
        has_px = 1'b1;
        word = '0;
        if (col < VISIBLE_COLUMNS && row < VISIBLE_ROWS) begin
          addr = longint'(row) * ROW_PITCH_BYTES + longint'(col) * 2;
          word = {frame_mem[addr % STORE_BYTES], frame_mem[(addr + 1) % STORE_BYTES]};
        end
        px.red   = {word[15:11], 3'b000};
        px.green = {word[10:5], 2'b00};
        px.blue  = {word[4:0], 3'b000};
      end
      default: ;
    endcase
    return has_px;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [7:0] value,
                           input logic [7:0] col, input logic [6:0] row,
                           input bit typed = 1'b0, input pixel_t typed_px = '0);
    pixel_t px;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, row, col, value};
    do @(posedge clk); while (!in_tready);
    if (lcd_apply(kind, value, col, row, px)) pixel_q.push_back(typed ? typed_px : px);
    sent_count++;
  endtask

  task automatic window_sequence(input logic [7:0] code, input int span_limit);
    logic [15:0] first, last;
    int          nbytes;
    if ($urandom_range(9) == 0) begin
      first = 16'($urandom);
      last  = 16'($urandom);
    end else begin
      first = 16'($urandom_range(span_limit - 1));
      last  = first + 16'($urandom_range(3));
    end
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(6) : 4;
    send_item(lwfc_pkg::KIND_CMD, code, 8'($urandom), 7'($urandom));
    for (int i = 0; i < nbytes; i++) begin
      case (i)
        0: send_item(lwfc_pkg::KIND_DATA, first[15:8], 8'($urandom), 7'($urandom));
        1: send_item(lwfc_pkg::KIND_DATA, first[7:0], 8'($urandom), 7'($urandom));
        2: send_item(lwfc_pkg::KIND_DATA, last[15:8], 8'($urandom), 7'($urandom));
        3: send_item(lwfc_pkg::KIND_DATA, last[7:0], 8'($urandom), 7'($urandom));
        default: send_item(lwfc_pkg::KIND_DATA, 8'($urandom), 8'($urandom), 7'($urandom));
      endcase
    end
  endtask

  task automatic read_sequence();
    int col, row;
    repeat ($urandom_range(1, 4)) begin
      // mostly aim at the window just written
      if ($urandom_range(4) != 0 && col_first <= col_last && col_last < VISIBLE_COLUMNS)
        col = $urandom_range(col_last, col_first);
      else
        col = $urandom_range(255);
      if ($urandom_range(4) != 0 && row_first <= row_last && row_last < VISIBLE_ROWS)
        row = $urandom_range(row_last, row_first);
      else
        row = $urandom_range(127);
      send_item(lwfc_pkg::KIND_READ, 8'($urandom), 8'(col), 7'(row));
    end
  endtask

  directed_row_t directed_rows [25] = '{
    '{lwfc_pkg::KIND_READ, 8'h00, 8'd0,   7'd0,   1'b1, '{8'h00, 8'h00, 8'h00}},
    '{lwfc_pkg::KIND_READ, 8'hFF, 8'd159, 7'd127, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{lwfc_pkg::KIND_READ, 8'h00, 8'd160, 7'd0,   1'b1, '{8'h00, 8'h00, 8'h00}},
    '{lwfc_pkg::KIND_READ, 8'h5A, 8'd255, 7'd127, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{lwfc_pkg::KIND_CMD,  lwfc_pkg::CMD_COLUMN_SET, 8'd0, 7'd0, 1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h00, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h01, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h00, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h02, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'hFF, 8'd255, 7'd127, 1'b0, '0},   // past the fourth byte
    '{lwfc_pkg::KIND_CMD,  lwfc_pkg::CMD_ROW_SET, 8'd0, 7'd0, 1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h00, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h05, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h00, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h06, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_CMD,  lwfc_pkg::CMD_MEMORY_WRITE, 8'd0, 7'd0, 1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'hFF, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'hFF, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h00, 8'd0,   7'd0,   1'b0, '0},
    '{KIND_UNUSED,         8'hAA, 8'd0,   7'd0,   1'b0, '0},   // must not break the write run
    '{lwfc_pkg::KIND_DATA, 8'h1F, 8'd0,   7'd0,   1'b0, '0},   // ends row 5, pointer wraps
    '{lwfc_pkg::KIND_READ, 8'h00, 8'd1,   7'd5,   1'b1, '{8'hF8, 8'hFC, 8'hF8}},
    '{lwfc_pkg::KIND_READ, 8'h00, 8'd2,   7'd5,   1'b1, '{8'hF8, 8'h00, 8'h00}},
    '{lwfc_pkg::KIND_CMD,  8'h00, 8'd0,   7'd0,   1'b0, '0},
    '{lwfc_pkg::KIND_DATA, 8'h55, 8'd0,   7'd0,   1'b0, '0}    // no active command
  };

  // result side: check, then pick next cycle's ready
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pixel_q.size() == 0) begin
        report_error($sformatf("unexpected pixel %06h", out_tdata));
      end else begin
        want = pixel_q.pop_front();
        if (got.red != want.red)
          report_error($sformatf("red %02h, expected %02h", got.red, want.red));
        if (got.green != want.green)
          report_error($sformatf("green %02h, expected %02h", got.green, want.green));
        if (got.blue != want.blue)
          report_error($sformatf("blue %02h, expected %02h", got.blue, want.blue));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("lcd_window_framebuffer_controller_test: errors");
        $finish;
      end
    end
  end

  initial begin
    bit drained_once;
    int pick;
    drained_once = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].col,
                directed_rows[i].row, directed_rows[i].typed, directed_rows[i].px);

    while (sent_count < TARGET_ITEMS) begin
      case (sent_count / 100)
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (sent_count / 100 == 2 && !drained_once) begin
        // hold off until every pending pixel is back
        drained_once = 1'b1;
        in_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 25) begin
        window_sequence(lwfc_pkg::CMD_COLUMN_SET, VISIBLE_COLUMNS);
      end else if (pick < 45) begin
        window_sequence(lwfc_pkg::CMD_ROW_SET, VISIBLE_ROWS);
      end else if (pick < 75) begin
        send_item(lwfc_pkg::KIND_CMD, lwfc_pkg::CMD_MEMORY_WRITE, 8'($urandom), 7'($urandom));
        repeat ($urandom_range(2, 12))
          send_item(lwfc_pkg::KIND_DATA, 8'($urandom), 8'($urandom), 7'($urandom));
      end else if (pick < 95) begin
        read_sequence();
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 7'($urandom));
      end
    end
    in_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("lcd_window_framebuffer_controller_test: clean");
    end else begin
      $display("lcd_window_framebuffer_controller_test: errors");
    end
    $finish;
  end

endmodule
